FILE: src/indexed_to_rgb16_blitter_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the indexed to rgb16 blitter
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef INDEXED_TO_RGB16_BLITTER_UNIT_ASSERT_SVH
`define INDEXED_TO_RGB16_BLITTER_UNIT_ASSERT_SVH

// Property holds at every clock edge out of reset.
`define IRGB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define IRGB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/irgb_pkg.sv
// ----------------------------------------------------------------------------
// irgb_pkg
// Shared constants, codes and the queue entry type of the blitter.
// ----------------------------------------------------------------------------
package irgb_pkg;

  localparam int ADDR_BITS  = 24;
  localparam int MAX_DIM    = 4096;
  localparam int DIM_BITS   = $clog2(MAX_DIM);
  localparam int CFG_DIM_W  = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int DM_W       = 3;
  localparam int STRIDE_W   = 16;
  localparam int COLOR_W    = 16;
  localparam int IDX_W      = 8;
  localparam int TADDR_W    = 9;
  localparam int MODE_W     = 2;
  localparam int PAL_DEPTH  = 256;
  localparam int LUT_HALF   = 256;
  localparam int LUT_AW     = $clog2(LUT_HALF);
  localparam int PIX_STEP   = 2;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRAW_MODE,
    REG_SOLID_COLOR,
    REG_ROW_WIDTH,
    REG_ROW_COUNT,
    REG_DEST_START,
    REG_DEST_ROW_BYTES
  } cfg_reg_e;

  typedef enum logic [DM_W-1:0] {
    DM_OPAQUE,
    DM_TRANSP,
    DM_OPAQUE_LUT,
    DM_TRANSP_LUT,
    DM_SOLID
  } draw_mode_e;

  typedef enum logic [MODE_W-1:0] {
    IN_PIXEL,
    IN_LOAD_PAL,
    IN_LOAD_LUT
  } in_mode_e;

  typedef enum logic [1:0] {
    K_PIXEL,
    K_PAL,
    K_LUT
  } kind_e;

  typedef enum logic [1:0] {
    CS_PAL,
    CS_LUT,
    CS_SOLID
  } csel_e;

  // For pixel entries table_value carries the solid color.
  typedef struct packed {
    kind_e                kind;
    logic                 we;
    csel_e                csel;
    logic [IDX_W-1:0]     pixel_index;
    logic [TADDR_W-1:0]   table_address;
    logic [COLOR_W-1:0]   table_value;
    logic [ADDR_BITS-1:0] dest_address;
    logic                 eor;
    logic                 eob;
  } entry_t;

  // Last column or row index after clamping the size to 1..MAX_DIM.
  function automatic logic [DIM_BITS-1:0] dim_last(input logic [CFG_DIM_W-1:0] n);
    logic [DIM_BITS-1:0] r;
    if (n == '0) begin
      r = '0;
    end else if (32'(n) > MAX_DIM) begin
      r = DIM_BITS'(MAX_DIM - 1);
    end else begin
      r = DIM_BITS'(n - 1'b1);
    end
    return r;
  endfunction

endpackage

FILE: src/irgb_if.sv
// ----------------------------------------------------------------------------
// irgb_if
// Valid/ready channels for source items and destination writes.
// ----------------------------------------------------------------------------
interface irgb_in_if import irgb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [IDX_W-1:0]   pixel_index;
  logic [TADDR_W-1:0] table_address;
  logic [COLOR_W-1:0] table_value;

  modport source (output valid, mode, pixel_index, table_address, table_value,
                  input ready);
  modport sink (input valid, mode, pixel_index, table_address, table_value,
                output ready);
endinterface

interface irgb_out_if import irgb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 write_enable;
  logic [ADDR_BITS-1:0] dest_address;
  logic [COLOR_W-1:0]   color;
  logic                 end_of_row;
  logic                 end_of_blit;

  modport source (output valid, write_enable, dest_address, color, end_of_row,
                  end_of_blit, input ready);
  modport sink (input valid, write_enable, dest_address, color, end_of_row,
                end_of_blit, output ready);
endinterface

FILE: src/irgb_ram.sv
// ----------------------------------------------------------------------------
// irgb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module irgb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/irgb_front.sv
// ----------------------------------------------------------------------------
// irgb_front
// Accepts items, holds the configuration, classifies each item and walks
// the destination address and row/column counters for pixels.
// ----------------------------------------------------------------------------
module irgb_front import irgb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  irgb_in_if.sink               in_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  full_i,
  output logic                  push_o,
  output entry_t                entry_o
);

  logic [DM_W-1:0]      draw_mode_q;
  logic [COLOR_W-1:0]   solid_q;
  logic [CFG_DIM_W-1:0] row_width_q;
  logic [CFG_DIM_W-1:0] row_count_q;
  logic [ADDR_BITS-1:0] dest_start_q;
  logic [STRIDE_W-1:0]  row_bytes_q;

  logic [DIM_BITS-1:0]  col_q, col_d;
  logic [DIM_BITS-1:0]  rows_q, rows_d;
  logic [ADDR_BITS-1:0] row_addr_q, row_addr_d;
  logic [ADDR_BITS-1:0] pix_addr_q, pix_addr_d;

  logic acc, is_pix, eor, eob, start_wr;
  logic [ADDR_BITS-1:0] next_row_addr;

  assign in_i.ready = !full_i;
  assign acc        = in_i.valid && in_i.ready;
  assign is_pix     = acc && (in_mode_e'(in_i.mode) == IN_PIXEL);
  assign start_wr   = cfg_we_i && (cfg_reg_e'(cfg_idx_i) == REG_DEST_START);

  assign eor = (col_q >= dim_last(row_width_q));
  assign eob = eor && (rows_q >= dim_last(row_count_q));

  assign next_row_addr = ADDR_BITS'(row_addr_q + ADDR_BITS'(row_bytes_q));

  // Classify the beat.
  always_comb begin
    entry_o.kind          = K_PIXEL;
    entry_o.we            = 1'b0;
    entry_o.csel          = CS_PAL;
    entry_o.pixel_index   = in_i.pixel_index;
    entry_o.table_address = in_i.table_address;
    entry_o.table_value   = in_i.table_value;
    entry_o.dest_address  = pix_addr_q;
    entry_o.eor           = eor;
    entry_o.eob           = eob;
    push_o                = 1'b0;
    case (in_mode_e'(in_i.mode))
      IN_PIXEL: begin
        push_o              = acc;
        entry_o.table_value = solid_q;
        case (draw_mode_e'(draw_mode_q))
          DM_OPAQUE: begin
            entry_o.we   = 1'b1;
            entry_o.csel = CS_PAL;
          end
          DM_TRANSP: begin
            entry_o.we   = (in_i.pixel_index != '0);
            entry_o.csel = CS_PAL;
          end
          DM_OPAQUE_LUT: begin
            entry_o.we   = 1'b1;
            entry_o.csel = CS_LUT;
          end
          DM_TRANSP_LUT: begin
            entry_o.we   = (in_i.pixel_index != '0);
            entry_o.csel = CS_LUT;
          end
          DM_SOLID: begin
            entry_o.we   = (in_i.pixel_index != '0);
            entry_o.csel = CS_SOLID;
          end
          default: begin
            entry_o.we = 1'b0;
          end
        endcase
      end
      IN_LOAD_PAL: begin
        // drop palette loads past the last entry
        push_o       = acc && (32'(in_i.table_address) < PAL_DEPTH);
        entry_o.kind = K_PAL;
      end
      IN_LOAD_LUT: begin
        push_o       = acc;
        entry_o.kind = K_LUT;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    col_d      = col_q;
    rows_d     = rows_q;
    row_addr_d = row_addr_q;
    pix_addr_d = pix_addr_q;
    if (start_wr) begin
      col_d      = '0;
      rows_d     = '0;
      row_addr_d = cfg_data_i[ADDR_BITS-1:0];
      pix_addr_d = cfg_data_i[ADDR_BITS-1:0];
    end else if (is_pix) begin
      if (eob) begin
        col_d      = '0;
        rows_d     = '0;
        row_addr_d = dest_start_q;
        pix_addr_d = dest_start_q;
      end else if (eor) begin
        col_d      = '0;
        rows_d     = rows_q + 1'b1;
        row_addr_d = next_row_addr;
        pix_addr_d = next_row_addr;
      end else begin
        col_d      = col_q + 1'b1;
        pix_addr_d = ADDR_BITS'(pix_addr_q + ADDR_BITS'(PIX_STEP));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draw_mode_q  <= '0;
      solid_q      <= '0;
      row_width_q  <= CFG_DIM_W'(1);
      row_count_q  <= CFG_DIM_W'(1);
      dest_start_q <= '0;
      row_bytes_q  <= '0;
      col_q        <= '0;
      rows_q       <= '0;
      row_addr_q   <= '0;
      pix_addr_q   <= '0;
    end else begin
      col_q      <= col_d;
      rows_q     <= rows_d;
      row_addr_q <= row_addr_d;
      pix_addr_q <= pix_addr_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_DRAW_MODE:      draw_mode_q  <= cfg_data_i[DM_W-1:0];
          REG_SOLID_COLOR:    solid_q      <= cfg_data_i[COLOR_W-1:0];
          REG_ROW_WIDTH:      row_width_q  <= cfg_data_i[CFG_DIM_W-1:0];
          REG_ROW_COUNT:      row_count_q  <= cfg_data_i[CFG_DIM_W-1:0];
          REG_DEST_START:     dest_start_q <= cfg_data_i[ADDR_BITS-1:0];
          REG_DEST_ROW_BYTES: row_bytes_q  <= cfg_data_i[STRIDE_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: src/irgb_queue.sv
// ----------------------------------------------------------------------------
// irgb_queue
// Short FIFO of classified entries between the front and the back.
// ----------------------------------------------------------------------------
module irgb_queue import irgb_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t head_o
);

  entry_t             mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_PTR_W:0]   count_q, count_d;

  assign full_o  = (count_q == (Q_PTR_W+1)'(Q_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers wrap naturally since the depth is a power of two.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

endmodule

FILE: src/irgb_back.sv
// ----------------------------------------------------------------------------
// irgb_back
// Executes entries in order: table loads, palette read, lookup read and add,
// then the output register.
// ----------------------------------------------------------------------------
module irgb_back import irgb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  entry_t    q_head_i,
  output logic      pop_o,
  irgb_out_if.source out_o
);

  logic adv;
  logic pal_we, lo_we, hi_we;
  logic [COLOR_W-1:0] pal_rdata, lo_rdata, hi_rdata;
  logic [COLOR_W-1:0] color_d;

  logic               s1_vld_q, s2_vld_q;
  entry_t             s1_q, s2_q;
  logic [COLOR_W-1:0] s2_pal_q;

  logic                 out_valid_q;
  logic                 out_we_q;
  logic [ADDR_BITS-1:0] out_addr_q;
  logic [COLOR_W-1:0]   out_color_q;
  logic                 out_eor_q;
  logic                 out_eob_q;

  // Whole pipeline advances together; hold everything while the output stalls.
  assign adv   = !out_valid_q || out_o.ready;
  assign pop_o = adv && q_valid_i;

  assign pal_we = pop_o && (q_head_i.kind == K_PAL);
  assign lo_we  = pop_o && (q_head_i.kind == K_LUT) && !q_head_i.table_address[TADDR_W-1];
  assign hi_we  = pop_o && (q_head_i.kind == K_LUT) && q_head_i.table_address[TADDR_W-1];

  irgb_ram #(.WIDTH(COLOR_W), .DEPTH(PAL_DEPTH)) u_pal (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (q_head_i.table_address[IDX_W-1:0]),
    .wdata_i (q_head_i.table_value),
    .re_i    (adv),
    .raddr_i (q_head_i.pixel_index),
    .rdata_o (pal_rdata)
  );

  // Lookup table split in halves: low byte indexes one, high byte the other.
  irgb_ram #(.WIDTH(COLOR_W), .DEPTH(LUT_HALF)) u_lut_lo (
    .clk_i   (clk_i),
    .we_i    (lo_we),
    .waddr_i (q_head_i.table_address[LUT_AW-1:0]),
    .wdata_i (q_head_i.table_value),
    .re_i    (adv),
    .raddr_i (pal_rdata[LUT_AW-1:0]),
    .rdata_o (lo_rdata)
  );

  irgb_ram #(.WIDTH(COLOR_W), .DEPTH(LUT_HALF)) u_lut_hi (
    .clk_i   (clk_i),
    .we_i    (hi_we),
    .waddr_i (q_head_i.table_address[LUT_AW-1:0]),
    .wdata_i (q_head_i.table_value),
    .re_i    (adv),
    .raddr_i (pal_rdata[COLOR_W-1:COLOR_W-LUT_AW]),
    .rdata_o (hi_rdata)
  );

  always_comb begin
    case (s2_q.csel)
      CS_PAL:   color_d = s2_pal_q;
      CS_LUT:   color_d = COLOR_W'(lo_rdata + hi_rdata);
      CS_SOLID: color_d = s2_q.table_value;
      default:  color_d = '0;
    endcase
    if (!s2_q.we) begin
      color_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q    <= pop_o && (q_head_i.kind == K_PIXEL);
      s2_vld_q    <= s1_vld_q;
      out_valid_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q        <= q_head_i;
      s2_q        <= s1_q;
      s2_pal_q    <= pal_rdata;
      out_we_q    <= s2_q.we;
      out_addr_q  <= s2_q.dest_address;
      out_color_q <= color_d;
      out_eor_q   <= s2_q.eor;
      out_eob_q   <= s2_q.eob;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.write_enable = out_we_q;
  assign out_o.dest_address = out_addr_q;
  assign out_o.color        = out_color_q;
  assign out_o.end_of_row   = out_eor_q;
  assign out_o.end_of_blit  = out_eob_q;

endmodule

FILE: src/indexed_to_rgb16_blitter_unit.sv
// ----------------------------------------------------------------------------
// indexed_to_rgb16_blitter_unit
// 8-bit palette-indexed pixels to 16-bit destination writes.
//
//   channel  dir  handshake     carries
//   in_i     in   valid/ready   mode, pixel_index, table_address, table_value
//   out_o    out  valid/ready   write_enable, dest_address, color, eor, eob
//   cfg      in   cfg_we_i      cfg_idx_i, cfg_data_i (write only)
//
// One beat per cycle sustained while out_o is not stalled; an accepted pixel
// goes through the queue, palette RAM read, lookup RAM read, output register.
// The tables need no clearing pass after reset; the block is ready at once.
// A stalled output freezes the back pipeline; the 4-entry queue then fills
// and in_i.ready drops only when it is full.
// ----------------------------------------------------------------------------
`include "indexed_to_rgb16_blitter_unit_assert.svh"

module indexed_to_rgb16_blitter_unit import irgb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  irgb_in_if.sink               in_i,
  irgb_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic   q_push, q_full, q_pop, q_valid;
  entry_t q_entry, q_head;

  irgb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .full_i     (q_full),
    .push_o     (q_push),
    .entry_o    (q_entry)
  );

  irgb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  irgb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_head_i  (q_head),
    .pop_o     (q_pop),
    .out_o     (out_o)
  );

  `IRGB_ASSERT(a_push_room, q_push |-> !q_full, "push into a full queue")
  `IRGB_ASSERT(a_pop_valid, q_pop |-> q_valid, "pop from an empty queue")
  `IRGB_ASSERT(a_stall_no_pop, (out_o.valid && !out_o.ready) |-> !q_pop, "pop during stall")
  `IRGB_ASSERT_NEXT(a_eob_eor, out_o.valid && out_o.end_of_blit, $past(out_o.end_of_row), "blit end without row end")

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks indexed_to_rgb16_blitter_unit: source beats (table loads, pixels and
// reserved items) go in with random gaps, and each destination write beat is
// compared field by field with the one that a behavioral blitter inside this
// bench works out for that pixel. Directed phases cover every draw mode, the
// extreme indexes and colors, address wrap, zero and oversized geometry. A
// short gapless run at the saturated width follows, and then random phases
// with new settings.
// ----------------------------------------------------------------------------
module tb;
  import irgb_pkg::*;

  localparam logic [MODE_W-1:0]    MODE_RESERVED   = 2'd3;
  localparam logic [DM_W-1:0]      DM_NO_WRITE_LO  = 3'd5;
  localparam logic [DM_W-1:0]      DM_NO_WRITE_HI  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED      = 3'd7;
  localparam int                   DRAIN_CYCLES    = 8;
  localparam int                   DRAIN_GUARD     = 50000;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [IDX_W-1:0]   idx;
    logic [TADDR_W-1:0] taddr;
    logic [COLOR_W-1:0] tval;
  } src_beat_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] addr;
    logic [COLOR_W-1:0]   color;
    logic                 eor;
    logic                 eob;
  } pix_write_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  irgb_in_if  in_if ();
  irgb_out_if out_if ();

  indexed_to_rgb16_blitter_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Source beats waiting to be driven, and destination writes still due.
  src_beat_t   beat_q[$];
  pix_write_t  pending_writes[$];
  src_beat_t   drv_beat;
  pix_write_t  mon_want;
  int unsigned n_queued;
  int unsigned n_taken;
  int unsigned err_cnt;
  bit          steady;

  // Behavioral blitter state.
  logic [COLOR_W-1:0]   pal_ram [PAL_DEPTH];
  logic [COLOR_W-1:0]   lut_ram [2*LUT_HALF];
  logic [DM_W-1:0]      dm;
  logic [COLOR_W-1:0]   solid;
  logic [CFG_DIM_W-1:0] row_w;
  logic [CFG_DIM_W-1:0] row_n;
  logic [ADDR_BITS-1:0] dstart;
  logic [STRIDE_W-1:0]  stride;
  int unsigned          col_cnt;
  int unsigned          row_cnt;
  logic [ADDR_BITS-1:0] row_addr;
  logic [ADDR_BITS-1:0] pix_addr;

  // What the source stream has loaded so far, seen at queue time.
  logic [COLOR_W-1:0] gen_pal [PAL_DEPTH];
  bit                 pal_loaded [PAL_DEPTH];
  bit                 lut_loaded [2*LUT_HALF];

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  task automatic restart_blit();
    col_cnt  = 0;
    row_cnt  = 0;
    row_addr = dstart;
    pix_addr = dstart;
  endtask

  function automatic int unsigned dim_bound(input logic [CFG_DIM_W-1:0] n);
    if (n == '0) begin
      return 1;
    end
    if (n > MAX_DIM) begin
      return MAX_DIM;
    end
    return n;
  endfunction

  function automatic logic [COLOR_W-1:0] lut_sum(input logic [COLOR_W-1:0] p);
    return lut_ram[{1'b0, p[7:0]}] + lut_ram[{1'b1, p[15:8]}];
  endfunction

  // Apply a table load, or work out the destination write that a pixel beat causes.
  task automatic expand_pixel_beat(input src_beat_t b);
    pix_write_t       w;
    logic [COLOR_W-1:0] p;
    int unsigned      w_lim;
    int unsigned      h_lim;
    case (b.mode)
      IN_LOAD_PAL: begin
        if (b.taddr < PAL_DEPTH) begin
          pal_ram[b.taddr[7:0]] = b.tval;
        end
      end
      IN_LOAD_LUT: lut_ram[b.taddr] = b.tval;
      IN_PIXEL: begin
        p = pal_ram[b.idx];
        w.we = 1'b0;
        w.color = '0;
        case (dm)
          DM_OPAQUE: begin
            w.we = 1'b1;
            w.color = p;
          end
          DM_TRANSP: begin
            w.we = (b.idx != '0);
            w.color = p;
          end
          DM_OPAQUE_LUT: begin
            w.we = 1'b1;
            w.color = lut_sum(p);
          end
          DM_TRANSP_LUT: begin
            w.we = (b.idx != '0);
            w.color = lut_sum(p);
          end
          DM_SOLID: begin
            w.we = (b.idx != '0);
            w.color = solid;
          end
          default: ;
        endcase
        if (!w.we) begin
          w.color = '0;
        end
        w_lim = dim_bound(row_w);
        h_lim = dim_bound(row_n);
        w.eor = (col_cnt >= w_lim - 1);
        w.eob = w.eor && (row_cnt >= h_lim - 1);
        w.addr = pix_addr;
        pending_writes.push_back(w);
        if (w.eob) begin
          restart_blit();
        end else if (w.eor) begin
          col_cnt  = 0;
          row_cnt++;
          row_addr = row_addr + ADDR_BITS'(stride);
          pix_addr = row_addr;
        end else begin
          col_cnt++;
          pix_addr = pix_addr + ADDR_BITS'(PIX_STEP);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && cfg_we_i) begin
      case (cfg_idx_i)
        REG_DRAW_MODE:      dm = cfg_data_i[DM_W-1:0];
        REG_SOLID_COLOR:    solid = cfg_data_i[COLOR_W-1:0];
        REG_ROW_WIDTH:      row_w = cfg_data_i[CFG_DIM_W-1:0];
        REG_ROW_COUNT:      row_n = cfg_data_i[CFG_DIM_W-1:0];
        REG_DEST_START: begin
          dstart = cfg_data_i[ADDR_BITS-1:0];
          restart_blit();
        end
        REG_DEST_ROW_BYTES: stride = cfg_data_i[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Source driver: predict on acceptance, then present the next beat.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid         <= 1'b0;
      in_if.mode          <= '0;
      in_if.pixel_index   <= '0;
      in_if.table_address <= '0;
      in_if.table_value   <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expand_pixel_beat(drv_beat);
        n_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (beat_q.size() != 0 && (steady || $urandom_range(99) >= 13)) begin
          drv_beat = beat_q.pop_front();
          in_if.valid         <= 1'b1;
          in_if.mode          <= drv_beat.mode;
          in_if.pixel_index   <= drv_beat.idx;
          in_if.table_address <= drv_beat.taddr;
          in_if.table_value   <= drv_beat.tval;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Destination monitor with random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pending_writes.size() == 0) begin
          report($sformatf("write beat at %06h with nothing expected",
                           out_if.dest_address));
        end else begin
          mon_want = pending_writes.pop_front();
          if (out_if.write_enable !== mon_want.we)
            report($sformatf("write_enable at %06h: got %b want %b",
                             mon_want.addr, out_if.write_enable, mon_want.we));
          if (out_if.dest_address !== mon_want.addr)
            report($sformatf("dest_address: got %06h want %06h",
                             out_if.dest_address, mon_want.addr));
          if (out_if.color !== mon_want.color)
            report($sformatf("color at %06h: got %04h want %04h",
                             mon_want.addr, out_if.color, mon_want.color));
          if (out_if.end_of_row !== mon_want.eor)
            report($sformatf("end_of_row at %06h: got %b want %b",
                             mon_want.addr, out_if.end_of_row, mon_want.eor));
          if (out_if.end_of_blit !== mon_want.eob)
            report($sformatf("end_of_blit at %06h: got %b want %b",
                             mon_want.addr, out_if.end_of_blit, mon_want.eob));
        end
      end
      out_if.ready <= steady || ($urandom_range(99) >= 13);
    end
  end

  task automatic push_beat(input logic [MODE_W-1:0] m, input logic [IDX_W-1:0] i,
                           input logic [TADDR_W-1:0] a, input logic [COLOR_W-1:0] v);
    src_beat_t b;
    b.mode  = m;
    b.idx   = i;
    b.taddr = a;
    b.tval  = v;
    beat_q.push_back(b);
    n_queued++;
  endtask

  task automatic push_pal_load(input logic [TADDR_W-1:0] a, input logic [COLOR_W-1:0] v);
    push_beat(IN_LOAD_PAL, IDX_W'($urandom), a, v);
    if (a < PAL_DEPTH) begin
      gen_pal[a[7:0]]    = v;
      pal_loaded[a[7:0]] = 1'b1;
    end
  endtask

  task automatic push_lut_load(input logic [TADDR_W-1:0] a, input logic [COLOR_W-1:0] v);
    push_beat(IN_LOAD_LUT, IDX_W'($urandom), a, v);
    lut_loaded[a] = 1'b1;
  endtask

  // Load any entries this pixel reads that are not yet loaded, before the pixel itself.
  task automatic push_pixel(input logic [IDX_W-1:0] idx);
    logic [COLOR_W-1:0] p;
    if (!pal_loaded[idx]) begin
      push_pal_load({1'b0, idx}, COLOR_W'($urandom));
    end
    p = gen_pal[idx];
    if (!lut_loaded[{1'b0, p[7:0]}]) begin
      push_lut_load({1'b0, p[7:0]}, COLOR_W'($urandom));
    end
    if (!lut_loaded[{1'b1, p[15:8]}]) begin
      push_lut_load({1'b1, p[15:8]}, COLOR_W'($urandom));
    end
    push_beat(IN_PIXEL, idx, TADDR_W'($urandom), COLOR_W'($urandom));
  endtask

  task automatic push_random_item();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) begin
      r = $urandom_range(99);
      if (r < 10) begin
        push_pixel('0);
      end else if (r < 15) begin
        push_pixel('1);
      end else begin
        push_pixel(IDX_W'($urandom));
      end
    end else if (r < 82) begin
      push_pal_load(TADDR_W'($urandom), COLOR_W'($urandom));
    end else if (r < 94) begin
      push_lut_load(TADDR_W'($urandom), COLOR_W'($urandom));
    end else begin
      push_beat(MODE_RESERVED, IDX_W'($urandom), TADDR_W'($urandom), COLOR_W'($urandom));
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Hold until every queued beat is taken and every write has come back.
  task automatic wait_idle();
    int guard;
    guard = 0;
    while ((n_taken != n_queued || pending_writes.size() != 0) && guard < DRAIN_GUARD) begin
      @(posedge clk_i);
      guard++;
    end
    if (guard >= DRAIN_GUARD) begin
      report($sformatf("%0d beats not taken, %0d writes still expected",
                       n_queued - n_taken, pending_writes.size()));
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [CFG_DIM_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 12) return '1;
    if (r < 15) return CFG_DIM_W'(MAX_DIM);
    return CFG_DIM_W'($urandom_range(1, 10));
  endfunction

  task automatic random_setup();
    int unsigned r;
    if ($urandom_range(99) < 85) begin
      cfg_write(REG_DRAW_MODE, CFG_DATA_W'($urandom_range(DM_SOLID)));
    end else begin
      cfg_write(REG_DRAW_MODE, CFG_DATA_W'($urandom_range(DM_NO_WRITE_LO, DM_NO_WRITE_HI)));
    end
    if ($urandom_range(99) < 70) cfg_write(REG_SOLID_COLOR, CFG_DATA_W'(COLOR_W'($urandom)));
    if ($urandom_range(99) < 70) cfg_write(REG_ROW_WIDTH, CFG_DATA_W'(pick_dim()));
    if ($urandom_range(99) < 70) cfg_write(REG_ROW_COUNT, CFG_DATA_W'(pick_dim()));
    if ($urandom_range(99) < 70) begin
      r = $urandom_range(99);
      if (r < 15) begin
        cfg_write(REG_DEST_ROW_BYTES, '0);
      end else if (r < 30) begin
        cfg_write(REG_DEST_ROW_BYTES, CFG_DATA_W'(16'hFFFF));
      end else begin
        cfg_write(REG_DEST_ROW_BYTES, CFG_DATA_W'(STRIDE_W'($urandom)));
      end
    end
    // Leave dest_start alone half the time so blits run across new geometry.
    if ($urandom_range(99) < 50) begin
      r = $urandom_range(99);
      if (r < 10) begin
        cfg_write(REG_DEST_START, 24'hFFFFFE);
      end else if (r < 20) begin
        cfg_write(REG_DEST_START, '0);
      end else begin
        cfg_write(REG_DEST_START, CFG_DATA_W'($urandom));
      end
    end
  endtask

  initial begin
    #3_000_000;
    $display("tb: errors");
    $finish;
  end

  initial begin
    logic [DM_W-1:0] dm_list [6];
    int              n;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= '0;
    cfg_data_i          <= '0;
    n_queued = 0;
    n_taken  = 0;
    err_cnt  = 0;
    steady   = 1'b0;
    dm     = DM_OPAQUE;
    solid  = '0;
    row_w  = CFG_DIM_W'(1);
    row_n  = CFG_DIM_W'(1);
    dstart = '0;
    stride = '0;
    restart_blit();
    foreach (pal_loaded[i]) pal_loaded[i] = 1'b0;
    foreach (lut_loaded[i]) lut_loaded[i] = 1'b0;
    foreach (gen_pal[i]) gen_pal[i] = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Two by two blit starting near the top of the address space.
    cfg_write(REG_DRAW_MODE, CFG_DATA_W'(DM_OPAQUE));
    cfg_write(REG_SOLID_COLOR, 24'h00FFFF);
    cfg_write(REG_ROW_WIDTH, CFG_DATA_W'(2));
    cfg_write(REG_ROW_COUNT, CFG_DATA_W'(2));
    cfg_write(REG_DEST_ROW_BYTES, 24'h00FFFF);
    cfg_write(REG_DEST_START, 24'hFFFFFC);
    cfg_write(REG_UNUSED, 24'hFFFFFF);

    push_pal_load('0, '0);
    push_pal_load(TADDR_W'(PAL_DEPTH - 1), 16'hFFFF);
    push_lut_load(TADDR_W'(LUT_HALF - 1), 16'hFFFF);
    push_lut_load('1, 16'hFFFF);
    push_pal_load(9'h12C, 16'hA5A5);
    push_beat(MODE_RESERVED, '1, '1, '1);
    push_pixel('0);
    push_pixel('1);
    push_pixel(8'h80);
    push_pixel(8'h01);
    wait_idle();

    dm_list = '{DM_TRANSP, DM_OPAQUE_LUT, DM_TRANSP_LUT, DM_SOLID,
                DM_NO_WRITE_LO, DM_NO_WRITE_HI};
    foreach (dm_list[k]) begin
      cfg_write(REG_DRAW_MODE, CFG_DATA_W'(dm_list[k]));
      push_pixel('0);
      push_pixel('1);
      push_pixel(IDX_W'($urandom));
      wait_idle();
    end

    // Zero sizes count as one: every pixel ends its row and the blit.
    cfg_write(REG_DRAW_MODE, CFG_DATA_W'(DM_TRANSP_LUT));
    cfg_write(REG_ROW_WIDTH, '0);
    cfg_write(REG_ROW_COUNT, '0);
    repeat (3) push_pixel(IDX_W'($urandom));
    wait_idle();

    // A run at the saturated width, with no gaps on either side.
    steady = 1'b1;
    cfg_write(REG_DRAW_MODE, CFG_DATA_W'(DM_OPAQUE_LUT));
    cfg_write(REG_ROW_WIDTH, CFG_DATA_W'(MAX_DIM + 1));
    cfg_write(REG_ROW_COUNT, CFG_DATA_W'(1));
    cfg_write(REG_DEST_START, CFG_DATA_W'($urandom));
    repeat (32) push_pixel(IDX_W'($urandom));
    wait_idle();
    steady = 1'b0;

    for (int ph = 0; ph < 8; ph++) begin
      random_setup();
      steady = (ph == 5);
      n = $urandom_range(12, 24);
      repeat (n) push_random_item();
      wait_idle();
      steady = 1'b0;
    end

    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
